/* rtl/voxel_face_ao_vertex_packer_macros.svh */
// Assertion helpers used by the pipeline top level.
`ifndef VOXEL_FACE_AO_VERTEX_PACKER_MACROS_SVH
`define VOXEL_FACE_AO_VERTEX_PACKER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define VFAO_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |-> (conseq)) else $error("vfao check failed");

// Next-cycle implication, checked outside reset.
`define VFAO_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |=> (conseq)) else $error("vfao check failed");

`else

`define VFAO_ASSERT_NOW(label, clk, rst_n, cond, conseq)
`define VFAO_ASSERT_NEXT(label, clk, rst_n, cond, conseq)

`endif

`endif

/* rtl/vfao_pkg.sv */
package vfao_pkg;

    localparam int MaskWidth = 26;

    localparam logic [2:0] FACE_FRONT = 3'd0;
    localparam logic [2:0] FACE_BACK  = 3'd1;
    localparam logic [2:0] FACE_LAST  = 3'd5;

    // Request fields that ride along the whole pipeline.
    typedef struct packed {
        logic [2:0] face;
        logic [4:0] pos_x;
        logic [4:0] pos_y;
        logic [4:0] pos_z;
        logic [5:0] tex_layer;
        logic [3:0] sun_level;
        logic [3:0] light_red;
        logic [3:0] light_green;
        logic [3:0] light_blue;
        logic       billboard;
    } t_attr;

    // After the first stage: three sampled neighbours per corner.
    typedef struct packed {
        t_attr           attr;
        logic            bad;
        logic [3:0][2:0] near;
    } t_pick;

    // After the second stage: four 2-bit occlusion values, corner 0 lowest.
    typedef struct packed {
        t_attr      attr;
        logic       bad;
        logic [7:0] ao;
    } t_shade;

    // Mask bit of side one, side two and the diagonal for each face and corner.
    // The centre cell has no bit, so cells above it are shifted down by one.
    // Faces six and seven are never valid; their rows are only there so that
    // a 3-bit face code indexes the whole table.
    localparam logic [4:0] CORNER_BIT [8][4][3] = '{
        '{'{5'd5,  5'd16, 5'd8 }, '{5'd22, 5'd16, 5'd25},
          '{5'd22, 5'd11, 5'd19}, '{5'd5,  5'd11, 5'd2 }},
        '{'{5'd20, 5'd14, 5'd23}, '{5'd3,  5'd14, 5'd6 },
          '{5'd3,  5'd9,  5'd0 }, '{5'd20, 5'd9,  5'd17}},
        '{'{5'd3,  5'd7,  5'd6 }, '{5'd5,  5'd7,  5'd8 },
          '{5'd5,  5'd1,  5'd2 }, '{5'd3,  5'd1,  5'd0 }},
        '{'{5'd22, 5'd24, 5'd25}, '{5'd20, 5'd24, 5'd23},
          '{5'd20, 5'd18, 5'd17}, '{5'd22, 5'd18, 5'd19}},
        '{'{5'd7,  5'd14, 5'd6 }, '{5'd24, 5'd14, 5'd23},
          '{5'd24, 5'd16, 5'd25}, '{5'd7,  5'd16, 5'd8 }},
        '{'{5'd1,  5'd11, 5'd2 }, '{5'd18, 5'd11, 5'd19},
          '{5'd18, 5'd9,  5'd17}, '{5'd1,  5'd9,  5'd0 }},
        '{'{5'd0,  5'd0,  5'd0 }, '{5'd0,  5'd0,  5'd0 },
          '{5'd0,  5'd0,  5'd0 }, '{5'd0,  5'd0,  5'd0 }},
        '{'{5'd0,  5'd0,  5'd0 }, '{5'd0,  5'd0,  5'd0 },
          '{5'd0,  5'd0,  5'd0 }, '{5'd0,  5'd0,  5'd0 }}
    };

endpackage

/* rtl/vfao_pick.sv */
module vfao_pick (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  vfao_pkg::t_attr               i_attr,
    input  logic [vfao_pkg::MaskWidth-1:0] i_mask,
    output logic                          o_valid,
    input  logic                          i_ready,
    output vfao_pkg::t_pick               o_pick
);

    logic            r_valid;
    vfao_pkg::t_pick r_pick;
    vfao_pkg::t_pick n_pick;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_pick.attr = i_attr;
        if (i_attr.billboard) begin
            n_pick.bad = (i_attr.face != vfao_pkg::FACE_FRONT) &&
                         (i_attr.face != vfao_pkg::FACE_BACK);
        end else begin
            n_pick.bad = i_attr.face > vfao_pkg::FACE_LAST;
        end
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 3; j++) begin
                n_pick.near[k][j] = i_mask[vfao_pkg::CORNER_BIT[i_attr.face][k][j]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pick <= n_pick;
        end
    end

    assign o_valid = r_valid;
    assign o_pick  = r_pick;

endmodule

/* rtl/vfao_shade.sv */
module vfao_shade (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  vfao_pkg::t_pick  i_pick,
    output logic             o_valid,
    input  logic             i_ready,
    output vfao_pkg::t_shade o_shade
);

    logic             r_valid;
    vfao_pkg::t_shade r_shade;
    vfao_pkg::t_shade n_shade;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        logic [1:0] count;
        n_shade.attr = i_pick.attr;
        n_shade.bad  = i_pick.bad;
        count        = 2'd0;
        for (int k = 0; k < 4; k++) begin
            // With both sides free of a full pair, at most two of three are set.
            count = 2'({1'b0, i_pick.near[k][0]} + {1'b0, i_pick.near[k][1]}
                       + {1'b0, i_pick.near[k][2]});
            if (i_pick.attr.billboard) begin
                n_shade.ao[2*k +: 2] = 2'd3;
            end else if (i_pick.near[k][0] && i_pick.near[k][1]) begin
                n_shade.ao[2*k +: 2] = 2'd0;
            end else begin
                n_shade.ao[2*k +: 2] = 2'd3 - count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_shade <= n_shade;
        end
    end

    assign o_valid = r_valid;
    assign o_shade = r_shade;

endmodule

/* rtl/vfao_pack.sv */
module vfao_pack (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  vfao_pkg::t_shade i_shade,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_vertex_low,
    output logic [15:0]      o_vertex_high,
    output logic             o_bad_face
);

    logic        r_valid;
    logic [31:0] r_low;
    logic [15:0] r_high;
    logic        r_bad;
    logic [31:0] n_low;
    logic [15:0] n_high;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        if (i_shade.bad) begin
            n_low  = 32'd0;
            n_high = 16'd0;
        end else begin
            n_low = {i_shade.ao, i_shade.attr.face, i_shade.attr.tex_layer,
                     i_shade.attr.pos_z, i_shade.attr.pos_y, i_shade.attr.pos_x};
            if (i_shade.attr.billboard) begin
                // Full sunlight and no block light.
                n_high = 16'h000F;
            end else begin
                n_high = {i_shade.attr.light_blue, i_shade.attr.light_green,
                          i_shade.attr.light_red, i_shade.attr.sun_level};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_low  <= n_low;
            r_high <= n_high;
            r_bad  <= i_shade.bad;
        end
    end

    assign o_valid       = r_valid;
    assign o_vertex_low  = r_low;
    assign o_vertex_high = r_high;
    assign o_bad_face    = r_bad;

endmodule

/* rtl/voxel_face_ao_vertex_packer.sv */
// Channel   Handshake           Payload
// request   i_valid / o_ready   i_face_sel, i_neighbour_mask, i_pos_*, i_tex_layer,
//                               i_sun_level, i_light_*, i_billboard
// vertex    o_valid / i_ready   o_vertex_low, o_vertex_high, o_bad_face
//
// One item per cycle is accepted and delivered while the vertex side is ready;
// there are three register stages (neighbour pick, occlusion, packing).
// Reset clears only the stage valid bits.
// Each stage takes a new item when it is empty or its item moves on, so a
// stall on the vertex side fills the stages before the request side stops.
`include "voxel_face_ao_vertex_packer_macros.svh"

module voxel_face_ao_vertex_packer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [2:0]                     i_face_sel,
    input  logic [vfao_pkg::MaskWidth-1:0] i_neighbour_mask,
    input  logic [4:0]                     i_pos_x,
    input  logic [4:0]                     i_pos_y,
    input  logic [4:0]                     i_pos_z,
    input  logic [5:0]                     i_tex_layer,
    input  logic [3:0]                     i_sun_level,
    input  logic [3:0]                     i_light_red,
    input  logic [3:0]                     i_light_green,
    input  logic [3:0]                     i_light_blue,
    input  logic                           i_billboard,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [31:0]                    o_vertex_low,
    output logic [15:0]                    o_vertex_high,
    output logic                           o_bad_face
);

    vfao_pkg::t_attr  attr;
    vfao_pkg::t_pick  pick;
    vfao_pkg::t_shade shade;
    logic             pick_valid;
    logic             pick_ready;
    logic             shade_valid;
    logic             shade_ready;

    always_comb begin
        attr.face        = i_face_sel;
        attr.pos_x       = i_pos_x;
        attr.pos_y       = i_pos_y;
        attr.pos_z       = i_pos_z;
        attr.tex_layer   = i_tex_layer;
        attr.sun_level   = i_sun_level;
        attr.light_red   = i_light_red;
        attr.light_green = i_light_green;
        attr.light_blue  = i_light_blue;
        attr.billboard   = i_billboard;
    end

    vfao_pick u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_attr  (attr),
        .i_mask  (i_neighbour_mask),
        .o_valid (pick_valid),
        .i_ready (pick_ready),
        .o_pick  (pick)
    );

    vfao_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pick_valid),
        .o_ready (pick_ready),
        .i_pick  (pick),
        .o_valid (shade_valid),
        .i_ready (shade_ready),
        .o_shade (shade)
    );

    vfao_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (shade_valid),
        .o_ready       (shade_ready),
        .i_shade       (shade),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_vertex_low  (o_vertex_low),
        .o_vertex_high (o_vertex_high),
        .o_bad_face    (o_bad_face)
    );

    // A rejected face always comes out as two zero words.
    `VFAO_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, o_valid && o_bad_face,
        o_vertex_low == 32'd0 && o_vertex_high == 16'd0)

    // A delivered good vertex never carries an unused face code.
    `VFAO_ASSERT_NOW(a_face_code, i_clk, i_rst_n, o_valid && !o_bad_face,
        o_vertex_low[23:21] != 3'd6 && o_vertex_low[23:21] != 3'd7)

    // An accepted request is held in the first stage on the next cycle.
    `VFAO_ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_valid && o_ready, pick_valid)

endmodule

/* sim/tb_voxel_face_ao_vertex_packer.sv */
module tb_voxel_face_ao_vertex_packer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FACE_LEFT   = 3'd2;
    localparam logic [2:0] FACE_BAD_LO = 3'd6;
    localparam logic [2:0] FACE_BAD_HI = 3'd7;

    localparam logic [1:0] AO_OPEN  = 2'd3;
    localparam logic [3:0] SUN_FULL = 4'hF;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_LIMIT = 10;

    // Per face and corner: side one, side two and diagonal as (x, y, z) offsets.
    localparam int NEIGHBOUR_OFS [6][4][3][3] = '{
        '{'{'{-1, 0, 1}, '{ 0, 1, 1}, '{-1, 1, 1}},
          '{'{ 1, 0, 1}, '{ 0, 1, 1}, '{ 1, 1, 1}},
          '{'{ 1, 0, 1}, '{ 0,-1, 1}, '{ 1,-1, 1}},
          '{'{-1, 0, 1}, '{ 0,-1, 1}, '{-1,-1, 1}}},
        '{'{'{ 1, 0,-1}, '{ 0, 1,-1}, '{ 1, 1,-1}},
          '{'{-1, 0,-1}, '{ 0, 1,-1}, '{-1, 1,-1}},
          '{'{-1, 0,-1}, '{ 0,-1,-1}, '{-1,-1,-1}},
          '{'{ 1, 0,-1}, '{ 0,-1,-1}, '{ 1,-1,-1}}},
        '{'{'{-1, 0,-1}, '{-1, 1, 0}, '{-1, 1,-1}},
          '{'{-1, 0, 1}, '{-1, 1, 0}, '{-1, 1, 1}},
          '{'{-1, 0, 1}, '{-1,-1, 0}, '{-1,-1, 1}},
          '{'{-1, 0,-1}, '{-1,-1, 0}, '{-1,-1,-1}}},
        '{'{'{ 1, 0, 1}, '{ 1, 1, 0}, '{ 1, 1, 1}},
          '{'{ 1, 0,-1}, '{ 1, 1, 0}, '{ 1, 1,-1}},
          '{'{ 1, 0,-1}, '{ 1,-1, 0}, '{ 1,-1,-1}},
          '{'{ 1, 0, 1}, '{ 1,-1, 0}, '{ 1,-1, 1}}},
        '{'{'{-1, 1, 0}, '{ 0, 1,-1}, '{-1, 1,-1}},
          '{'{ 1, 1, 0}, '{ 0, 1,-1}, '{ 1, 1,-1}},
          '{'{ 1, 1, 0}, '{ 0, 1, 1}, '{ 1, 1, 1}},
          '{'{-1, 1, 0}, '{ 0, 1, 1}, '{-1, 1, 1}}},
        '{'{'{-1,-1, 0}, '{ 0,-1, 1}, '{-1,-1, 1}},
          '{'{ 1,-1, 0}, '{ 0,-1, 1}, '{ 1,-1, 1}},
          '{'{ 1,-1, 0}, '{ 0,-1,-1}, '{ 1,-1,-1}},
          '{'{-1,-1, 0}, '{ 0,-1,-1}, '{-1,-1,-1}}}
    };

    typedef struct {
        logic [2:0]                     face;
        logic [vfao_pkg::MaskWidth-1:0] mask;
        logic [4:0]                     pos_x;
        logic [4:0]                     pos_y;
        logic [4:0]                     pos_z;
        logic [5:0]                     layer;
        logic [3:0]                     sun;
        logic [3:0]                     red;
        logic [3:0]                     green;
        logic [3:0]                     blue;
        logic                           billboard;
    } t_face_req;

    typedef struct {
        logic [31:0] low;
        logic [15:0] high;
        logic        bad;
    } t_vertex;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [2:0]                     i_face_sel;
    logic [vfao_pkg::MaskWidth-1:0] i_neighbour_mask;
    logic [4:0]                     i_pos_x;
    logic [4:0]                     i_pos_y;
    logic [4:0]                     i_pos_z;
    logic [5:0]                     i_tex_layer;
    logic [3:0]                     i_sun_level;
    logic [3:0]                     i_light_red;
    logic [3:0]                     i_light_green;
    logic [3:0]                     i_light_blue;
    logic                           i_billboard;
    logic                           o_valid;
    logic                           i_ready;
    logic [31:0]                    o_vertex_low;
    logic [15:0]                    o_vertex_high;
    logic                           o_bad_face;

    t_vertex expected_vertices [$];
    int      fail_count     = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      ready_idle_pct = 0;

    voxel_face_ao_vertex_packer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_face_sel       (i_face_sel),
        .i_neighbour_mask (i_neighbour_mask),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_tex_layer      (i_tex_layer),
        .i_sun_level      (i_sun_level),
        .i_light_red      (i_light_red),
        .i_light_green    (i_light_green),
        .i_light_blue     (i_light_blue),
        .i_billboard      (i_billboard),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_vertex_low     (o_vertex_low),
        .o_vertex_high    (o_vertex_high),
        .o_bad_face       (o_bad_face)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mask bit of one sampled neighbour; the centre cell has no bit of its own.
    function automatic int neighbour_bit(int face, int corner, int n);
        int cell_num;
        cell_num = (NEIGHBOUR_OFS[face][corner][n][0] + 1) * 9
                 + (NEIGHBOUR_OFS[face][corner][n][1] + 1) * 3
                 + (NEIGHBOUR_OFS[face][corner][n][2] + 1);
        return (cell_num > 13) ? cell_num - 1 : cell_num;
    endfunction

    function automatic t_vertex predict_vertex(t_face_req r);
        t_vertex    v;
        logic [7:0] ao;
        int         side_a;
        int         side_b;
        int         diag;
        v.low  = '0;
        v.high = '0;
        v.bad  = 1'b0;
        if ((r.billboard && r.face > vfao_pkg::FACE_BACK)
                || (!r.billboard && r.face > vfao_pkg::FACE_LAST)) begin
            v.bad = 1'b1;
            return v;
        end
        if (r.billboard) begin
            ao     = {4{AO_OPEN}};
            v.high = {12'h000, SUN_FULL};
        end else begin
            for (int k = 0; k < 4; k++) begin
                side_a = r.mask[neighbour_bit(r.face, k, 0)];
                side_b = r.mask[neighbour_bit(r.face, k, 1)];
                diag   = r.mask[neighbour_bit(r.face, k, 2)];
                // Two occupied sides close the corner no matter the diagonal.
                if (side_a == 1 && side_b == 1) begin
                    ao[2*k +: 2] = 2'd0;
                end else begin
                    ao[2*k +: 2] = 2'(3 - (side_a + side_b + diag));
                end
            end
            v.high = {r.blue, r.green, r.red, r.sun};
        end
        v.low = {ao, r.face, r.layer, r.pos_z, r.pos_y, r.pos_x};
        return v;
    endfunction

    task automatic send_request(input t_face_req r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_face_sel       <= r.face;
        i_neighbour_mask <= r.mask;
        i_pos_x          <= r.pos_x;
        i_pos_y          <= r.pos_y;
        i_pos_z          <= r.pos_z;
        i_tex_layer      <= r.layer;
        i_sun_level      <= r.sun;
        i_light_red      <= r.red;
        i_light_green    <= r.green;
        i_light_blue     <= r.blue;
        i_billboard      <= r.billboard;
        i_valid          <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        expected_vertices.push_back(predict_vertex(r));
    endtask

    function automatic t_face_req random_request();
        t_face_req r;
        int        pick;
        pick        = $urandom_range(99);
        r.mask      = vfao_pkg::MaskWidth'($urandom);
        r.pos_x     = 5'($urandom);
        r.pos_y     = 5'($urandom);
        r.pos_z     = 5'($urandom);
        r.layer     = 6'($urandom);
        r.sun       = 4'($urandom);
        r.red       = 4'($urandom);
        r.green     = 4'($urandom);
        r.blue      = 4'($urandom);
        // Sparse and dense masks push the corners toward bright and dark.
        case ($urandom_range(3))
            0: begin
                r.mask &= vfao_pkg::MaskWidth'($urandom);
            end
            1: begin
                r.mask |= vfao_pkg::MaskWidth'($urandom);
            end
            default: begin
            end
        endcase
        if (pick < 78) begin
            r.face      = 3'($urandom_range(vfao_pkg::FACE_LAST));
            r.billboard = 1'b0;
        end else if (pick < 90) begin
            r.face      = 3'($urandom_range(vfao_pkg::FACE_BACK));
            r.billboard = 1'b1;
        end else begin
            r.face      = 3'($urandom);
            r.billboard = 1'($urandom);
        end
        return r;
    endfunction

    task automatic test_faces_open_and_closed();
        t_face_req r;
        for (int f = vfao_pkg::FACE_FRONT; f <= vfao_pkg::FACE_LAST; f++) begin
            r = '{face: 3'(f), mask: '0, pos_x: '0, pos_y: '0, pos_z: '0, layer: '0,
                  sun: '0, red: '0, green: '0, blue: '0, billboard: 1'b0};
            send_request(r);
            r = '{face: 3'(f), mask: '1, pos_x: '1, pos_y: '1, pos_z: '1, layer: '1,
                  sun: '1, red: '1, green: '1, blue: '1, billboard: 1'b0};
            send_request(r);
        end
    endtask

    // All eight combinations of side one, side two and diagonal on one corner.
    task automatic test_corner_patterns();
        t_face_req r;
        for (int p = 0; p < 8; p++) begin
            r = random_request();
            r.face      = vfao_pkg::FACE_FRONT;
            r.billboard = 1'b0;
            r.mask      = '0;
            for (int n = 0; n < 3; n++) begin
                if (p[n]) begin
                    r.mask[neighbour_bit(vfao_pkg::FACE_FRONT, 0, n)] = 1'b1;
                end
            end
            send_request(r);
        end
    endtask

    task automatic test_billboard();
        t_face_req r;
        r = random_request();
        r.billboard = 1'b1;
        r.face      = vfao_pkg::FACE_FRONT;
        send_request(r);
        r = random_request();
        r.billboard = 1'b1;
        r.face      = vfao_pkg::FACE_BACK;
        send_request(r);
    endtask

    task automatic test_bad_faces();
        t_face_req r;
        r = random_request();
        r.billboard = 1'b0;
        r.face      = FACE_BAD_LO;
        send_request(r);
        r.face      = FACE_BAD_HI;
        send_request(r);
        r.billboard = 1'b1;
        r.face      = FACE_LEFT;
        send_request(r);
        r.face      = FACE_BAD_HI;
        send_request(r);
    endtask

    task automatic test_random(input int count, input int send_idle, input int ready_idle);
        send_idle_pct  = send_idle;
        ready_idle_pct = ready_idle;
        repeat (count) send_request(random_request());
    endtask

    always @(posedge i_clk) begin : vertex_check
        t_vertex exp_v;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_vertices.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected vertex: low=%h high=%h bad=%b",
                             o_vertex_low, o_vertex_high, o_bad_face);
                end
            end else begin
                exp_v = expected_vertices.pop_front();
                if (o_vertex_low !== exp_v.low || o_vertex_high !== exp_v.high
                        || o_bad_face !== exp_v.bad) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display({"vertex mismatch: expected low=%h high=%h bad=%b,",
                                  " got low=%h high=%h bad=%b"},
                                 exp_v.low, exp_v.high, exp_v.bad,
                                 o_vertex_low, o_vertex_high, o_bad_face);
                    end
                end
            end
        end
        i_ready <= ($urandom_range(99) >= ready_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_ready          <= 1'b0;
        i_face_sel       <= '0;
        i_neighbour_mask <= '0;
        i_pos_x          <= '0;
        i_pos_y          <= '0;
        i_pos_z          <= '0;
        i_tex_layer      <= '0;
        i_sun_level      <= '0;
        i_light_red      <= '0;
        i_light_green    <= '0;
        i_light_blue     <= '0;
        i_billboard      <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 22;
        ready_idle_pct = 83;
        test_faces_open_and_closed();
        test_corner_patterns();
        test_billboard();
        test_bad_faces();
        test_random(550, 22, 83);
        test_random(550, 83, 22);
        test_random(550, 0, 0);
        i_valid <= 1'b0;

        while (expected_vertices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_vertices.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* voxel_face_ao_vertex_packer.f */
+incdir+rtl
rtl/vfao_pkg.sv
rtl/vfao_pick.sv
rtl/vfao_shade.sv
rtl/vfao_pack.sv
rtl/voxel_face_ao_vertex_packer.sv
sim/tb_voxel_face_ao_vertex_packer.sv
